// ===== src/abts_pkg.sv =====
// ----------------------------------------------------------------------------
// abts_pkg
// Shared types and constants for the affine bilinear texture sampler.
// ----------------------------------------------------------------------------
package abts_pkg;

	localparam int MAX_SIDE   = 256;
	localparam int TEX_TEXELS = 65536;
	localparam int ADDR_W     = $clog2(TEX_TEXELS);
	localparam int SIDE_W     = $clog2(MAX_SIDE) + 1;
	localparam int COORD_W    = $clog2(MAX_SIDE);

	typedef enum logic [1:0] {
		ACT_WRITE = 2'd0,
		ACT_SETPOS = 2'd1,
		ACT_SAMPLE = 2'd2,
		ACT_NONE = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		EDGE_CLIP = 2'd0,
		EDGE_WRAP = 2'd1,
		EDGE_MASK = 2'd2,
		EDGE_SPARE = 2'd3
	} edge_t;

	typedef enum logic [2:0] {
		REG_WIDTH = 3'd0,
		REG_HEIGHT = 3'd1,
		REG_EDGE = 3'd2,
		REG_SMOOTH = 3'd3,
		REG_ALPHA = 3'd4,
		REG_STEP_X = 3'd5,
		REG_STEP_Y = 3'd6,
		REG_SPARE = 3'd7
	} reg_index_t;

	typedef struct packed {
		logic [1:0]         action;
		logic [15:0]        texel_address;
		logic [31:0]        texel_value;
		logic signed [31:0] start_x;
		logic signed [31:0] start_y;
	} in_item_t;

	typedef struct packed {
		logic [7:0] channel_0;
		logic [7:0] channel_1;
		logic [7:0] channel_2;
		logic [7:0] alpha;
	} out_item_t;

	typedef struct packed {
		logic [2:0]  index;
		logic [31:0] data;
	} cfg_beat_t;

endpackage

// ===== src/abts_wrap.sv =====
// ----------------------------------------------------------------------------
// abts_wrap
// Iterative edge mapping of one signed coordinate onto a side: clamp, mask,
// or non-negative remainder by restoring subtraction, one bit per cycle.
// ----------------------------------------------------------------------------
module abts_wrap
	import abts_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [16:0]  coord,
	input  logic [SIDE_W-1:0]   side,
	input  logic [1:0]          mode,
	output logic                done,
	output logic [COORD_W-1:0]  result
);

	localparam int DIV_STEPS = 17;

	logic [4:0]        cnt_q;
	logic              busy_q;
	logic              neg_q;
	logic [16:0]       mag_q;
	logic [SIDE_W:0]   rem_q;
	logic [SIDE_W-1:0] side_q;
	logic [COORD_W-1:0] res_q;
	logic              done_q;

	logic [SIDE_W+1:0] trial;
	logic [SIDE_W:0]   rem_next;
	logic [16:0]       abs_coord;
	logic [SIDE_W:0]   fixed_rem;

	assign abs_coord = coord[16] ? 17'(-coord) : coord;
	assign trial     = {rem_q, mag_q[16]} - {2'b00, side_q};
	assign rem_next  = trial[SIDE_W+1] ? {rem_q[SIDE_W-1:0], mag_q[16]} : trial[SIDE_W:0];
	// negative remainder folds back into range
	assign fixed_rem = (neg_q && rem_next != '0) ? ({1'b0, side_q} - rem_next) : rem_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				if (mode == EDGE_WRAP) begin
					busy_q <= 1'b1;
					cnt_q  <= '0;
					neg_q  <= coord[16];
					mag_q  <= abs_coord;
					rem_q  <= '0;
					side_q <= side;
				end else begin
					done_q <= 1'b1;
					if (mode == EDGE_MASK)
						res_q <= COORD_W'(coord) & COORD_W'(side - 1'b1);
					else if (coord[16])
						res_q <= '0;
					else if ({1'b0, coord} >= 18'(side))
						res_q <= COORD_W'(side - 1'b1);
					else
						res_q <= COORD_W'(coord);
				end
			end else if (busy_q) begin
				rem_q <= rem_next;
				mag_q <= {mag_q[15:0], 1'b0};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 5'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					res_q  <= COORD_W'(fixed_rem);
				end
			end
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

// ===== src/affine_bilinear_texture_sampler_unit.sv =====
// ----------------------------------------------------------------------------
// affine_bilinear_texture_sampler_unit
// Texel store with nearest or bilinear sampling along a 16.16 affine span.
// ----------------------------------------------------------------------------
//  channel   direction  handshake       payload
//  cfg       in         cfg_valid/ready cfg_beat_t (index, data)
//  in        in         in_valid/ready  in_item_t
//  out       out        out_valid/ready out_item_t
//
// write and set-position beats are handled without leaving idle. a sample maps
// two (nearest) or four (bilinear) coordinates through one shared edge unit,
// reads one or four texels, and in bilinear mode blends each channel with one
// shared multiplier. reset clears control state and the position; texel memory
// is not cleared. the in channel is not ready while a sample is in work or its
// pixel is not taken; the next beat is taken in the cycle after the pixel leaves.
module affine_bilinear_texture_sampler_unit
	import abts_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  cfg_beat_t cfg,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out
);

	typedef enum logic [3:0] {
		S_IDLE, S_MAP, S_MAPWAIT, S_READ, S_RDWAIT, S_MUL, S_OUT
	} state_t;

	state_t state_q;

	logic [8:0]  width_q, height_q;
	logic [1:0]  edge_q;
	logic        smooth_q, alpha_q;
	logic [31:0] step_x_q, step_y_q, pos_x_q, pos_y_q;

	logic [31:0] mem [TEX_TEXELS];
	logic [31:0] rd_data_q;

	logic [SIDE_W-1:0] w_side, h_side;
	logic [1:0]  mode_eff;
	logic [1:0]  idx_q;        // map step or read step
	logic [COORD_W-1:0] cx0_q, cx1_q, cy0_q, cy1_q;
	logic [31:0] p_q [4];
	logic [7:0]  fx_q;
	logic [15:0] fy_q;

	logic              wrap_start;
	logic signed [16:0] wrap_coord;
	logic [SIDE_W-1:0] wrap_side;
	logic              wrap_done;
	logic [COORD_W-1:0] wrap_res;

	// blend sequencing
	logic [3:0]  mstep_q;
	logic [1:0]  ch_q;
	logic [16:0] mul_a;
	logic [16:0] mul_b;
	logic [33:0] mul_p;
	logic [16:0] hx0_q, hx1_q;
	logic [35:0] acc_q;
	logic [7:0]  res_q [4];
	out_item_t   out_q;

	logic [ADDR_W-1:0] rd_addr;
	logic [COORD_W-1:0] rrow, rcol;

	assign w_side = (width_q == '0) ? SIDE_W'(1) :
		(width_q > 9'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : SIDE_W'(width_q);
	assign h_side = (height_q == '0) ? SIDE_W'(1) :
		(height_q > 9'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : SIDE_W'(height_q);
	assign mode_eff = (edge_q == EDGE_SPARE) ? EDGE_CLIP : edge_q;

	// map steps: 0 x0, 1 x1, 2 y0, 3 y1
	always_comb begin
		case (idx_q)
			2'd0: wrap_coord = {pos_x_q[31], pos_x_q[31:16]};
			2'd1: wrap_coord = {pos_x_q[31], pos_x_q[31:16]} + 17'sd1;
			2'd2: wrap_coord = {pos_y_q[31], pos_y_q[31:16]};
			default: wrap_coord = {pos_y_q[31], pos_y_q[31:16]} + 17'sd1;
		endcase
	end
	assign wrap_side  = idx_q[1] ? h_side : w_side;
	assign wrap_start = (state_q == S_MAP);

	abts_wrap u_wrap (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (wrap_start),
		.coord  (wrap_coord),
		.side   (wrap_side),
		.mode   (mode_eff),
		.done   (wrap_done),
		.result (wrap_res)
	);

	// read order: p00 p01 p10 p11
	assign rrow = idx_q[1] ? cy1_q : cy0_q;
	assign rcol = idx_q[0] ? cx1_q : cx0_q;
	assign rd_addr = ADDR_W'(32'(rrow) * 32'(w_side) + 32'(rcol));

	always_ff @(posedge clk) begin
		if (in_valid && in_ready && in.action == ACT_WRITE)
			mem[in.texel_address[ADDR_W-1:0]] <= in.texel_value;
		rd_data_q <= mem[rd_addr];
	end

	// clamp-mode x1/y1: same texel when negative or at or past the last one
	function automatic logic at_edge(input logic [15:0] c, input logic [SIDE_W-1:0] s);
		at_edge = c[15] || ({1'b0, c} >= 17'(s) - 17'd1);
	endfunction

	function automatic logic [7:0] chan(input logic [31:0] p, input logic [1:0] c);
		chan = p[8*c +: 8];
	endfunction

	// shared multiplier: steps 0..3 form x sums, 4..5 scale by y weights
	always_comb begin
		case (mstep_q)
			4'd0: begin mul_a = 17'(chan(p_q[0], ch_q)); mul_b = 17'(9'h100 - 9'(fx_q)); end
			4'd1: begin mul_a = 17'(chan(p_q[1], ch_q)); mul_b = 17'(fx_q); end
			4'd2: begin mul_a = 17'(chan(p_q[2], ch_q)); mul_b = 17'(9'h100 - 9'(fx_q)); end
			4'd3: begin mul_a = 17'(chan(p_q[3], ch_q)); mul_b = 17'(fx_q); end
			4'd4: begin mul_a = hx0_q; mul_b = 17'h10000 - 17'(fy_q); end
			default: begin mul_a = hx1_q; mul_b = 17'(fy_q); end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			width_q  <= 9'd1;
			height_q <= 9'd1;
			edge_q   <= EDGE_CLIP;
			smooth_q <= 1'b0;
			alpha_q  <= 1'b0;
			step_x_q <= 32'h0001_0000;
			step_y_q <= '0;
			pos_x_q  <= '0;
			pos_y_q  <= '0;
			idx_q    <= '0;
			mstep_q  <= '0;
			ch_q     <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (reg_index_t'(cfg.index))
					REG_WIDTH:  width_q  <= cfg.data[8:0];
					REG_HEIGHT: height_q <= cfg.data[8:0];
					REG_EDGE:   edge_q   <= cfg.data[1:0];
					REG_SMOOTH: smooth_q <= cfg.data[0];
					REG_ALPHA:  alpha_q  <= cfg.data[0];
					REG_STEP_X: step_x_q <= cfg.data;
					REG_STEP_Y: step_y_q <= cfg.data;
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (in.action == ACT_SETPOS) begin
							pos_x_q <= in.start_x;
							pos_y_q <= in.start_y;
						end else if (in.action == ACT_SAMPLE) begin
							idx_q   <= smooth_q ? 2'd0 : 2'd0;
							fx_q    <= pos_x_q[15:8];
							fy_q    <= pos_y_q[15:0];
							state_q <= S_MAP;
						end
					end
				end
				S_MAP: state_q <= S_MAPWAIT;
				S_MAPWAIT: begin
					if (wrap_done) begin
						case (idx_q)
							2'd0: cx0_q <= wrap_res;
							2'd1: cx1_q <= wrap_res;
							2'd2: cy0_q <= wrap_res;
							default: cy1_q <= wrap_res;
						endcase
						if (!smooth_q && idx_q == 2'd0) begin
							idx_q <= 2'd2;
							state_q <= S_MAP;
						end else if (idx_q == 2'd3 || (!smooth_q && idx_q == 2'd2)) begin
							idx_q <= '0;
							state_q <= S_READ;
						end else begin
							idx_q <= idx_q + 1'b1;
							state_q <= S_MAP;
						end
					end
				end
				S_READ: begin
					// clamp neighbours collapse onto the base texel
					if (mode_eff == EDGE_CLIP) begin
						if (at_edge(pos_x_q[31:16], w_side)) cx1_q <= cx0_q;
						if (at_edge(pos_y_q[31:16], h_side)) cy1_q <= cy0_q;
					end
					state_q <= S_RDWAIT;
				end
				S_RDWAIT: begin
					p_q[idx_q] <= rd_data_q;
					if (!smooth_q) begin
						res_q[0] <= rd_data_q[7:0];
						res_q[1] <= rd_data_q[15:8];
						res_q[2] <= rd_data_q[23:16];
						res_q[3] <= rd_data_q[31:24];
						state_q  <= S_OUT;
					end else if (idx_q == 2'd3) begin
						mstep_q <= '0;
						ch_q    <= '0;
						state_q <= S_MUL;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_READ;
					end
				end
				S_MUL: begin
					case (mstep_q)
						4'd0, 4'd2: begin
							if (mstep_q == 4'd0) hx0_q <= 17'(mul_p);
							else hx1_q <= 17'(mul_p);
						end
						4'd1: hx0_q <= hx0_q + 17'(mul_p);
						4'd3: hx1_q <= hx1_q + 17'(mul_p);
						4'd4: acc_q <= 36'(mul_p);
						default: ;
					endcase
					if (mstep_q == 4'd5) begin
						res_q[ch_q] <= 8'((acc_q + 36'(mul_p)) >> 24);
						mstep_q <= '0;
						if (ch_q == 2'd3) state_q <= S_OUT;
						ch_q <= ch_q + 1'b1;
					end else begin
						mstep_q <= mstep_q + 1'b1;
					end
				end
				S_OUT: begin
					if (out_ready) begin
						pos_x_q <= pos_x_q + step_x_q;
						pos_y_q <= pos_y_q + step_y_q;
						idx_q   <= '0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		out_q.channel_0 = res_q[0];
		out_q.channel_1 = res_q[1];
		out_q.channel_2 = res_q[2];
		out_q.alpha     = alpha_q ? res_q[3] : 8'd255;
	end

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign out       = out_q;

endmodule
